// ===== hdl/sitda_pkg.sv =====
package sitda_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
  localparam int unsigned CNT_W      = $clog2(VALUE_W);
  localparam int unsigned REM_W      = $clog2(NUM_DIGITS + 1);
  localparam int unsigned CHAR_W     = 8;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

  // valid flag and sign handed from the converter to the character sequencer; digits travel on bcd
  typedef struct packed {
    logic valid;
    logic neg;
  } conv_t;

  function automatic logic bcd_ok(input logic [BCD_W-1:0] bcd);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] > 4'd9) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

// ===== hdl/sitda_dabble.sv =====
module sitda_dabble (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [sitda_pkg::VALUE_W-1:0]   value,
  output logic                            idle,
  output sitda_pkg::conv_t                hand,
  output logic [sitda_pkg::BCD_W-1:0]     bcd,
  input  logic                            take
);

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_CONV = 3'b010,
    D_HOLD = 3'b100
  } dab_state_t;

  dab_state_t                        state_r, state_nxt;
  logic [sitda_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [sitda_pkg::VALUE_W-1:0]     mag_r, mag_nxt;
  logic [sitda_pkg::BCD_W-1:0]       bcd_r, bcd_nxt;
  logic                              neg_r, neg_nxt;
  logic [sitda_pkg::BCD_W-1:0]       adj;

  // add 3 to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < sitda_pkg::NUM_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? (bcd_r[4*i +: 4] + 4'd3)
                                                 : bcd_r[4*i +: 4];
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    mag_nxt   = mag_r;
    bcd_nxt   = bcd_r;
    neg_nxt   = neg_r;
    unique case (state_r)
      D_IDLE: begin
        if (start) begin
          neg_nxt   = value[sitda_pkg::VALUE_W-1];
          mag_nxt   = value[sitda_pkg::VALUE_W-1] ? (~value + 32'd1) : value;
          bcd_nxt   = '0;
          cnt_nxt   = '1;
          state_nxt = D_CONV;
        end
      end
      D_CONV: begin
        bcd_nxt = {adj[sitda_pkg::BCD_W-2:0], mag_r[sitda_pkg::VALUE_W-1]};
        mag_nxt = {mag_r[sitda_pkg::VALUE_W-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = D_HOLD;
        end
      end
      D_HOLD: begin
        if (take) begin
          state_nxt = D_IDLE;
        end
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r <= cnt_nxt;
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
    neg_r <= neg_nxt;
  end

  assign idle       = (state_r == D_IDLE);
  assign hand.valid = (state_r == D_HOLD);
  assign hand.neg   = neg_r;
  assign bcd        = bcd_r;

`ifndef SYNTHESIS
  a_hold_bcd_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == D_HOLD) |-> sitda_pkg::bcd_ok(bcd_r))
    else $error("converter holds a digit above nine");

  a_conv_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == D_CONV && cnt_r == '0) |=> (state_r == D_HOLD))
    else $error("conversion did not finish after the last shift");
`endif

endmodule

// ===== hdl/sitda_emit.sv =====
module sitda_emit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sitda_pkg::conv_t                   hand,
  input  logic [sitda_pkg::BCD_W-1:0]        bcd,
  output logic                               take,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [sitda_pkg::CHAR_W-1:0]       out_char_code,
  output logic                               out_is_last
);

  typedef enum logic [3:0] {
    E_IDLE  = 4'b0001,
    E_SKIP  = 4'b0010,
    E_SIGN  = 4'b0100,
    E_DIGIT = 4'b1000
  } emit_state_t;

  localparam int unsigned TOP = sitda_pkg::BCD_W - 4;

  emit_state_t                        state_r, state_nxt;
  logic [sitda_pkg::BCD_W-1:0]        sh_r, sh_nxt;
  logic [sitda_pkg::REM_W-1:0]        rem_r, rem_nxt;
  logic                               neg_r, neg_nxt;
  logic                               valid_r, valid_nxt;
  logic [sitda_pkg::CHAR_W-1:0]       char_r, char_nxt;
  logic                               last_r, last_nxt;
  logic                               can_emit;
  logic [3:0]                         top_dig;

  assign top_dig  = sh_r[TOP +: 4];
  assign can_emit = !valid_r || out_ready;
  assign take     = (state_r == E_IDLE);

  always_comb begin
    state_nxt = state_r;
    sh_nxt    = sh_r;
    rem_nxt   = rem_r;
    neg_nxt   = neg_r;
    valid_nxt = valid_r;
    char_nxt  = char_r;
    last_nxt  = last_r;
    if (valid_r && out_ready) begin
      valid_nxt = 1'b0;
    end
    unique case (state_r)
      E_IDLE: begin
        if (hand.valid) begin
          sh_nxt    = bcd;
          neg_nxt   = hand.neg;
          rem_nxt   = sitda_pkg::REM_W'(sitda_pkg::NUM_DIGITS);
          state_nxt = E_SKIP;
        end
      end
      E_SKIP: begin
        // drop leading zeros one digit a cycle, keep at least one digit
        if (top_dig == 4'd0 && rem_r > sitda_pkg::REM_W'(1)) begin
          sh_nxt  = {sh_r[TOP-1:0], 4'd0};
          rem_nxt = rem_r - 1'b1;
        end else begin
          state_nxt = neg_r ? E_SIGN : E_DIGIT;
        end
      end
      E_SIGN: begin
        if (can_emit) begin
          valid_nxt = 1'b1;
          char_nxt  = sitda_pkg::CHAR_MINUS;
          last_nxt  = 1'b0;
          state_nxt = E_DIGIT;
        end
      end
      E_DIGIT: begin
        if (can_emit) begin
          valid_nxt = 1'b1;
          char_nxt  = sitda_pkg::CHAR_ZERO + {4'd0, top_dig};
          last_nxt  = (rem_r == sitda_pkg::REM_W'(1));
          sh_nxt    = {sh_r[TOP-1:0], 4'd0};
          rem_nxt   = rem_r - 1'b1;
          if (rem_r == sitda_pkg::REM_W'(1)) begin
            state_nxt = E_IDLE;
          end
        end
      end
      default: state_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    sh_r   <= sh_nxt;
    rem_r  <= rem_nxt;
    neg_r  <= neg_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign out_valid     = valid_r;
  assign out_char_code = char_r;
  assign out_is_last   = last_r;

`ifndef SYNTHESIS
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && char_r == sitda_pkg::CHAR_MINUS) |-> !last_r)
    else $error("minus sign marked as last character");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && char_r != sitda_pkg::CHAR_MINUS) |->
      (char_r >= sitda_pkg::CHAR_ZERO && char_r <= sitda_pkg::CHAR_ZERO + 8'd9))
    else $error("character is neither sign nor digit");

  a_digits_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == E_DIGIT || state_r == E_SIGN) |-> (rem_r != '0))
    else $error("sequencer emitting with no digits left");
`endif

endmodule

// ===== hdl/signed_int_to_decimal_ascii.sv =====
// channel   ports                                   meaning
// input     in_valid, in_ready, in_value[31:0]      signed integer, one per transaction
// output    out_valid, out_ready, out_char_code[7:0], out_is_last
//                                                   one ascii character per transaction
// conversion shifts one magnitude bit per cycle through the bcd shift register
// leading zeros are then dropped at one digit per cycle, then one character per cycle unless out_ready stalls it
// a new value is accepted while the previous one is still being sent as characters
// out_ready low stalls the character sequencer, and then the converter once it is full
// rst_n is synchronous and active low; it clears both state machines and out_valid
module signed_int_to_decimal_ascii (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [sitda_pkg::VALUE_W-1:0] in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [sitda_pkg::CHAR_W-1:0]       out_char_code,
  output logic                               out_is_last
);

  sitda_pkg::conv_t                  hand;
  logic [sitda_pkg::BCD_W-1:0]       bcd;
  logic                              take;
  logic                              idle;

  assign in_ready = idle;

  sitda_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_valid && idle),
    .value (in_value),
    .idle  (idle),
    .hand  (hand),
    .bcd   (bcd),
    .take  (take)
  );

  sitda_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .hand          (hand),
    .bcd           (bcd),
    .take          (take),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_is_last   (out_is_last)
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned RADIX       = 10;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES = 100;
  localparam int unsigned PHASE_ITEMS = 48;

  typedef struct packed {
    logic signed [sitda_pkg::VALUE_W-1:0] source;
    logic [sitda_pkg::CHAR_W-1:0]         char_code;
    logic                                 is_last;
  } ascii_char_t;

  logic                                   clk;
  logic                                   rst_n         = 1'b0;
  logic                                   in_valid      = 1'b0;
  logic                                   in_ready;
  logic signed [sitda_pkg::VALUE_W-1:0]   in_value      = '0;
  logic                                   out_valid;
  logic                                   out_ready     = 1'b0;
  logic [sitda_pkg::CHAR_W-1:0]           out_char_code;
  logic                                   out_is_last;

  logic signed [sitda_pkg::VALUE_W-1:0]   pending_values [$];
  ascii_char_t                            expected_chars [$];
  logic                                   value_taken   = 1'b0;
  int unsigned                            sender_idle_pct    = 0;
  int unsigned                            receiver_stall_pct = 0;
  int unsigned                            mismatches    = 0;
  int unsigned                            values_sent   = 0;
  int unsigned                            negatives_sent = 0;
  int unsigned                            chars_checked = 0;
  int unsigned                            stall_cycles  = 0;

  signed_int_to_decimal_ascii dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_is_last   (out_is_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // expected decimal text of one value, most significant character first
  task automatic render_decimal(input logic signed [sitda_pkg::VALUE_W-1:0] value);
    logic [sitda_pkg::VALUE_W-1:0] magnitude;
    logic [3:0]                    digit_stack [sitda_pkg::NUM_DIGITS];
    int                            ndig;
    ascii_char_t                   ch;
    magnitude = value[sitda_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
    ndig = 0;
    do begin
      digit_stack[ndig] = 4'(magnitude % RADIX);
      magnitude = magnitude / RADIX;
      ndig++;
    end while (magnitude != 0 && ndig < sitda_pkg::NUM_DIGITS);
    ch.source = value;
    if (value[sitda_pkg::VALUE_W-1]) begin
      ch.char_code = sitda_pkg::CHAR_MINUS;
      ch.is_last = 1'b0;
      expected_chars.push_back(ch);
    end
    for (int d = ndig - 1; d >= 0; d--) begin
      ch.char_code = sitda_pkg::CHAR_ZERO + sitda_pkg::CHAR_W'(digit_stack[d]);
      ch.is_last = (d == 0);
      expected_chars.push_back(ch);
    end
  endtask

  function automatic logic signed [sitda_pkg::VALUE_W-1:0] random_value();
    logic [sitda_pkg::VALUE_W-1:0] mag;
    int unsigned                   pick;
    int unsigned                   scale;
    pick = $urandom_range(0, 7);
    scale = 1;
    repeat ($urandom_range(1, 9)) scale = scale * RADIX;
    case (pick)
      0, 1: mag = $urandom;
      2: mag = scale;
      3: mag = scale - 1;
      default: mag = $urandom % scale;
    endcase
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || value_taken) begin
        if (pending_values.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          in_value <= pending_values.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    ascii_char_t want;
    logic        out_taken;
    value_taken = rst_n && in_valid && in_ready;
    out_taken = rst_n && out_valid && out_ready;
    if (out_taken) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                  out_char_code, out_is_last));
      end else begin
        want = expected_chars.pop_front();
        chars_checked++;
        if (out_char_code !== want.char_code) begin
          report_mismatch($sformatf("value %0d: char 0x%02h, expected 0x%02h",
                                    want.source, out_char_code, want.char_code));
        end
        if (out_is_last !== want.is_last) begin
          report_mismatch($sformatf("value %0d: is_last %0b, expected %0b",
                                    want.source, out_is_last, want.is_last));
        end
      end
    end
    if (value_taken) begin
      render_decimal(in_value);
      values_sent++;
      if (in_value < 0) negatives_sent++;
    end
    if (rst_n && !value_taken && !out_taken && (in_valid || expected_chars.size() != 0)) begin
      stall_cycles++;
    end else begin
      stall_cycles = 0;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_values.size() != 0 || in_valid || expected_chars.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (PHASE_ITEMS) pending_values.push_back(random_value());
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed values: zero, sign, digit count boundaries, extremes
    pending_values.push_back(32'sd0);
    pending_values.push_back(32'sd1);
    pending_values.push_back(-32'sd1);
    pending_values.push_back(32'sd9);
    pending_values.push_back(32'sd10);
    pending_values.push_back(-32'sd10);
    pending_values.push_back(32'sd99);
    pending_values.push_back(32'sd100);
    pending_values.push_back(-32'sd5);
    pending_values.push_back(32'sd123456789);
    pending_values.push_back(32'sd999999999);
    pending_values.push_back(-32'sd999999999);
    pending_values.push_back(32'sd1000000000);
    pending_values.push_back(-32'sd1000000000);
    pending_values.push_back(32'sh7FFF_FFFF);
    pending_values.push_back(32'sh8000_0000);
    pending_values.push_back(32'sh8000_0001);
    pending_values.push_back(32'shFFFF_FFFE);
    pending_values.push_back(32'sh5555_5555);
    pending_values.push_back(32'shAAAA_AAAA);
    wait_drained();

    run_phase(0, 0);
    run_phase(69, 0);
    run_phase(0, 69);
    run_phase(11, 11);

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("converted %0d values (%0d negative) into %0d checked characters",
             values_sent, negatives_sent, chars_checked);
    $display("phases: no idling, sender idle, receiver stalling, both; %0d mismatches",
             mismatches);
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== signed_int_to_decimal_ascii.f =====
hdl/sitda_pkg.sv
hdl/sitda_dabble.sv
hdl/sitda_emit.sv
hdl/signed_int_to_decimal_ascii.sv
verif/tb_top.sv
